### sv/ktcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktcd_pkg
// Shared types, codes and constants of the keyed table with compacting delete.
// ----------------------------------------------------------------------------
package ktcd_pkg;

    // field widths fixed by the request and response formats
    localparam int KEY_W = 32;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int ACT_W = 3;
    localparam int STS_W = 3;

    // default table size
    localparam int TABLE_DEPTH_DEF = 64;

    // request codes
    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_SEARCH = 3'd2,
        ACT_UPDATE = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_LIST   = 3'd5
    } action_t;

    // response status codes
    typedef enum logic [STS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_MISSING = 3'd4
    } status_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic signed [KEY_W-1:0] item_key;
        logic signed [KEY_W-1:0] item_quantity;
    } req_item_t;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic signed [KEY_W-1:0] found_key;
        logic signed [KEY_W-1:0] found_quantity;
        logic [IDX_W-1:0]  entry_index;
        logic [CNT_W-1:0]  entry_count;
        logic              last;
    } rsp_item_t;

    // one stored table entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] qty;
    } entry_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_APPEND,
        S_UPDATE,
        S_SHIFT,
        S_EMIT,
        S_LIST_RD,
        S_LIST_EMIT
    } ctl_state_t;

    // write port source
    typedef enum logic [1:0] {
        WR_APPEND,
        WR_UPDATE,
        WR_SHIFT
    } wr_sel_t;

    // response payload source
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_ENTRY,
        SRC_LIST
    } out_src_t;

    // controller to datapath
    typedef struct packed {
        logic     load_req;
        logic     ptr_clr;
        logic     ptr_inc;
        logic     ptr_load_next;
        logic     rd_en;
        logic     hit_capture;
        logic     ent_from_req;
        logic     ent_qty_from_req;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     cnt_clr;
        logic     out_load;
        status_t  out_status;
        out_src_t out_src;
        logic     out_last;
    } ktcd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             count_zero;
        logic             count_full;
        logic             ptr_at_end;
        logic             ret_valid;
        logic             hit;
        logic             ret_last;
        logic             out_free;
    } ktcd_sts_t;

endpackage

### sv/keyed_table_with_compacting_delete_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_table_with_compacting_delete_top
// Bounded table of (key, quantity) entries kept packed in insertion order,
// with add, delete with compaction, search, update, clear and list requests.
// ----------------------------------------------------------------------------
//  channel   signals                          transfer when
//  request   req_valid, req_ready, req_item   req_valid && req_ready
//  response  rsp_valid, rsp_ready, rsp_item   rsp_valid && rsp_ready
//
//  One request at a time. A key scan reads one entry per cycle from the
//  entry memory, which has one read and one write port, and compares each
//  returned entry with the request key; an add that misses then appends.
//  A delete moves each later entry down one place. List reads one entry,
//  then emits it, before it reads the next.
//  Reset clears the entry count, scan pointer and valid flags; entry memory
//  needs no clearing pass.
//  A stalled response holds the sequencer in its emit step; a new request
//  is taken as soon as the last response of the previous one is registered.
// ----------------------------------------------------------------------------
module keyed_table_with_compacting_delete_top
    import ktcd_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req_item,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp_item
);

    ktcd_cmd_t cmd;
    ktcd_sts_t sts;

    // sequencer
    ktcd_controller u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table storage and response register
    ktcd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp_item  (rsp_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### sv/ktcd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktcd_datapath
// Entry memory, scan pointer, entry count, request holding and response
// register of the keyed table.
// ----------------------------------------------------------------------------
module ktcd_datapath
    import ktcd_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_item_t req_item,
    input  logic      rsp_ready,
    output logic      rsp_valid,
    output rsp_item_t rsp_item,
    input  ktcd_cmd_t cmd,
    output ktcd_sts_t sts
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // entry storage
    entry_t mem [TABLE_DEPTH];

    req_item_t req_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;
    logic          ret_valid_reg;
    logic [AW-1:0] ret_idx_reg;
    entry_t        rdata_reg;
    entry_t        ent_reg;
    logic [AW-1:0] pos_reg;
    logic          out_valid_reg;
    rsp_item_t     out_reg;

    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    rsp_item_t     out_next;
    logic [CW-1:0] ret_next_idx;

    assign ret_next_idx = CW'(ret_idx_reg) + CW'(1);

    // status toward the controller
    always_comb
    begin
        sts.action     = req_reg.action;
        sts.count_zero = (count_reg == '0);
        sts.count_full = (count_reg >= CW'(TABLE_DEPTH));
        sts.ptr_at_end = (ptr_reg >= count_reg);
        sts.ret_valid  = ret_valid_reg;
        sts.hit        = (rdata_reg.key == req_reg.item_key);
        sts.ret_last   = (ret_next_idx == count_reg);
        sts.out_free   = !out_valid_reg || rsp_ready;
    end

    // write port selection
    always_comb
    begin
        case (cmd.wr_sel)
            WR_APPEND:
            begin
                wr_addr     = count_reg[AW-1:0];
                wr_data.key = req_reg.item_key;
                wr_data.qty = req_reg.item_quantity;
            end
            WR_UPDATE:
            begin
                wr_addr     = pos_reg;
                wr_data.key = ent_reg.key;
                wr_data.qty = req_reg.item_quantity;
            end
            WR_SHIFT:
            begin
                wr_addr = ret_idx_reg - AW'(1);
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_addr = pos_reg;
                wr_data = rdata_reg;
            end
        endcase
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    // response payload selection
    always_comb
    begin
        out_next.status      = cmd.out_status;
        out_next.entry_count = CNT_W'(count_reg);
        out_next.last        = cmd.out_last;
        case (cmd.out_src)
            SRC_ENTRY:
            begin
                out_next.found_key      = ent_reg.key;
                out_next.found_quantity = ent_reg.qty;
                out_next.entry_index    = IDX_W'(pos_reg);
            end
            SRC_LIST:
            begin
                out_next.found_key      = rdata_reg.key;
                out_next.found_quantity = rdata_reg.qty;
                out_next.entry_index    = IDX_W'(ret_idx_reg);
            end
            default:
            begin
                out_next.found_key      = '0;
                out_next.found_quantity = '0;
                out_next.entry_index    = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            ret_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end

            if (cmd.ptr_clr)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.ptr_load_next)
            begin
                ptr_reg <= ret_next_idx;
            end
            else if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_reg + CW'(1);
            end

            ret_valid_reg <= cmd.rd_en;

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_item;
        end
        if (cmd.rd_en)
        begin
            ret_idx_reg <= ptr_reg[AW-1:0];
        end
        if (cmd.hit_capture)
        begin
            ent_reg <= rdata_reg;
            pos_reg <= ret_idx_reg;
        end
        else if (cmd.ent_from_req)
        begin
            ent_reg.key <= req_reg.item_key;
            ent_reg.qty <= req_reg.item_quantity;
            pos_reg     <= count_reg[AW-1:0];
        end
        else if (cmd.ent_qty_from_req)
        begin
            ent_reg.qty <= req_reg.item_quantity;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule

### sv/ktcd_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktcd_controller
// Request sequencer: decodes a request, runs the key scan, append, update,
// compacting shift and list walk, and schedules each response transfer.
// ----------------------------------------------------------------------------
module ktcd_controller
    import ktcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  ktcd_sts_t sts,
    output ktcd_cmd_t cmd
);

    ctl_state_t state_reg, state_next;
    status_t    emit_status_reg, emit_status_next;
    out_src_t   emit_src_reg, emit_src_next;

    // state and pending response registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            emit_status_reg <= ST_OK;
            emit_src_reg    <= SRC_NONE;
        end
        else
        begin
            state_reg       <= state_next;
            emit_status_reg <= emit_status_next;
            emit_src_reg    <= emit_src_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next       = state_reg;
        emit_status_next = emit_status_reg;
        emit_src_next    = emit_src_reg;
        req_ready        = 1'b0;
        cmd              = '0;
        cmd.wr_sel       = WR_APPEND;
        cmd.out_status   = emit_status_reg;
        cmd.out_src      = emit_src_reg;

        case (state_reg)
            S_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                cmd.ptr_clr = 1'b1;
                case (sts.action)
                    ACT_ADD:
                    begin
                        if (sts.count_full)
                        begin
                            emit_status_next = ST_FULL;
                            emit_src_next    = SRC_NONE;
                            state_next       = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (sts.count_zero)
                        begin
                            emit_status_next = ST_EMPTY;
                            emit_src_next    = SRC_NONE;
                            state_next       = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    ACT_SEARCH, ACT_UPDATE:
                    begin
                        state_next = S_SCAN;
                    end
                    ACT_CLEAR:
                    begin
                        cmd.cnt_clr      = 1'b1;
                        emit_status_next = ST_OK;
                        emit_src_next    = SRC_NONE;
                        state_next       = S_EMIT;
                    end
                    ACT_LIST:
                    begin
                        if (sts.count_zero)
                        begin
                            emit_status_next = ST_EMPTY;
                            emit_src_next    = SRC_NONE;
                            state_next       = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_LIST_RD;
                        end
                    end
                    default:
                    begin
                        // unknown request: no response
                        state_next = S_IDLE;
                    end
                endcase
            end

            // one read issued and one entry compared per cycle
            S_SCAN:
            begin
                if (sts.ret_valid && sts.hit)
                begin
                    cmd.hit_capture = 1'b1;
                    case (sts.action)
                        ACT_ADD:
                        begin
                            emit_status_next = ST_DUP;
                            emit_src_next    = SRC_ENTRY;
                            state_next       = S_EMIT;
                        end
                        ACT_DELETE:
                        begin
                            cmd.ptr_load_next = 1'b1;
                            state_next        = S_SHIFT;
                        end
                        ACT_UPDATE:
                        begin
                            state_next = S_UPDATE;
                        end
                        default:
                        begin
                            emit_status_next = ST_OK;
                            emit_src_next    = SRC_ENTRY;
                            state_next       = S_EMIT;
                        end
                    endcase
                end
                else if (!sts.ret_valid && sts.ptr_at_end)
                begin
                    if (sts.action == ACT_ADD)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        emit_status_next = ST_MISSING;
                        emit_src_next    = SRC_NONE;
                        state_next       = S_EMIT;
                    end
                end
                else
                begin
                    cmd.rd_en   = !sts.ptr_at_end;
                    cmd.ptr_inc = !sts.ptr_at_end;
                end
            end

            S_APPEND:
            begin
                cmd.wr_en        = 1'b1;
                cmd.wr_sel       = WR_APPEND;
                cmd.ent_from_req = 1'b1;
                cmd.cnt_inc      = 1'b1;
                emit_status_next = ST_OK;
                emit_src_next    = SRC_ENTRY;
                state_next       = S_EMIT;
            end

            S_UPDATE:
            begin
                cmd.wr_en            = 1'b1;
                cmd.wr_sel           = WR_UPDATE;
                cmd.ent_qty_from_req = 1'b1;
                emit_status_next     = ST_OK;
                emit_src_next        = SRC_ENTRY;
                state_next           = S_EMIT;
            end

            // move each later entry down one place, one per cycle
            S_SHIFT:
            begin
                cmd.wr_sel  = WR_SHIFT;
                cmd.wr_en   = sts.ret_valid;
                cmd.rd_en   = !sts.ptr_at_end;
                cmd.ptr_inc = !sts.ptr_at_end;
                if (!sts.ret_valid && sts.ptr_at_end)
                begin
                    cmd.cnt_dec      = 1'b1;
                    emit_status_next = ST_OK;
                    emit_src_next    = SRC_ENTRY;
                    state_next       = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_LIST_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next  = S_LIST_EMIT;
            end

            S_LIST_EMIT:
            begin
                cmd.out_status = ST_OK;
                cmd.out_src    = SRC_LIST;
                cmd.out_last   = sts.ret_last;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.ret_last ? S_IDLE : S_LIST_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed table with compacting delete. A directed
// pass covers the empty table, key and quantity extremes, duplicates,
// compaction at the first, middle and last position, and reserved request
// codes. A random pass then mixes requests on a small live key set and
// fills the table to capacity. A scoreboard keeps its own copy of the
// table, predicts every response and checks each one field by field.
// ----------------------------------------------------------------------------
module testbench;
    import ktcd_pkg::*;

    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int IDLE_MAX  = 4000;
    localparam int HOLD_LEN  = 400;
    localparam int DRAIN_LEN = 300;
    localparam int MIXED_OPS = 12;

    // request codes the block must ignore
    localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd7;

    // shadow table and queue of predicted responses
    class table_scoreboard;
        logic [KEY_W-1:0] keys [DEPTH];
        logic [KEY_W-1:0] qtys [DEPTH];
        int               used;
        rsp_item_t        awaited [$];
        int unsigned      errors;

        function new();
            used   = 0;
            errors = 0;
        endfunction

        function int locate(logic [KEY_W-1:0] k);
            for (int i = 0; i < used; i++)
            begin
                if (keys[i] == k)
                    return i;
            end
            return -1;
        endfunction

        function string show(rsp_item_t r);
            return $sformatf("status=%0d key=%h qty=%h index=%0d count=%0d last=%0d",
                             r.status, r.found_key, r.found_quantity, r.entry_index,
                             r.entry_count, r.last);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        function void queue_result(status_t st, int idx, logic [KEY_W-1:0] k,
                                   logic [KEY_W-1:0] q, bit last);
            rsp_item_t r;
            r.status         = st;
            r.found_key      = k;
            r.found_quantity = q;
            r.entry_index    = idx[IDX_W-1:0];
            r.entry_count    = used[CNT_W-1:0];
            r.last           = last;
            awaited.push_back(r);
        endfunction

        // apply one accepted request to the shadow table
        function void note_request(req_item_t rq);
            int               pos;
            logic [KEY_W-1:0] k;
            logic [KEY_W-1:0] q;
            pos = locate(rq.item_key);
            case (rq.action)
                ACT_ADD:
                begin
                    if (used >= DEPTH)
                        queue_result(ST_FULL, 0, '0, '0, 1'b1);
                    else if (pos >= 0)
                        queue_result(ST_DUP, pos, keys[pos], qtys[pos], 1'b1);
                    else
                    begin
                        keys[used] = rq.item_key;
                        qtys[used] = rq.item_quantity;
                        used++;
                        queue_result(ST_OK, used - 1, keys[used - 1], qtys[used - 1], 1'b1);
                    end
                end
                ACT_DELETE:
                begin
                    if (used == 0)
                        queue_result(ST_EMPTY, 0, '0, '0, 1'b1);
                    else if (pos < 0)
                        queue_result(ST_MISSING, 0, '0, '0, 1'b1);
                    else
                    begin
                        k = keys[pos];
                        q = qtys[pos];
                        for (int i = pos; i + 1 < used; i++)
                        begin
                            keys[i] = keys[i + 1];
                            qtys[i] = qtys[i + 1];
                        end
                        used--;
                        queue_result(ST_OK, pos, k, q, 1'b1);
                    end
                end
                ACT_SEARCH:
                begin
                    if (pos < 0)
                        queue_result(ST_MISSING, 0, '0, '0, 1'b1);
                    else
                        queue_result(ST_OK, pos, keys[pos], qtys[pos], 1'b1);
                end
                ACT_UPDATE:
                begin
                    if (pos < 0)
                        queue_result(ST_MISSING, 0, '0, '0, 1'b1);
                    else
                    begin
                        qtys[pos] = rq.item_quantity;
                        queue_result(ST_OK, pos, keys[pos], qtys[pos], 1'b1);
                    end
                end
                ACT_CLEAR:
                begin
                    used = 0;
                    queue_result(ST_OK, 0, '0, '0, 1'b1);
                end
                ACT_LIST:
                begin
                    if (used == 0)
                        queue_result(ST_EMPTY, 0, '0, '0, 1'b1);
                    else
                    begin
                        for (int i = 0; i < used; i++)
                            queue_result(ST_OK, i, keys[i], qtys[i], i == used - 1);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // compare one response transfer with the oldest prediction
        function void check_response(rsp_item_t got);
            rsp_item_t want;
            string     diff;
            if (awaited.size() == 0)
            begin
                flag({"unexpected response: ", show(got)});
                return;
            end
            want = awaited.pop_front();
            diff = "";
            if (got.status !== want.status)
                diff = {diff, " status"};
            if (got.found_key !== want.found_key)
                diff = {diff, " found_key"};
            if (got.found_quantity !== want.found_quantity)
                diff = {diff, " found_quantity"};
            if (got.entry_index !== want.entry_index)
                diff = {diff, " entry_index"};
            if (got.entry_count !== want.entry_count)
                diff = {diff, " entry_count"};
            if (got.last !== want.last)
                diff = {diff, " last"};
            if (diff != "")
                flag({"field", diff, "\n  expected ", show(want), "\n  actual   ", show(got)});
        endfunction

        function void check_drained();
            while (awaited.size() != 0)
                flag({"response never arrived: ", show(awaited.pop_front())});
        endfunction
    endclass

    logic            clk;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_ready;
    req_item_t       req_item  = '0;
    logic            rsp_valid;
    logic            rsp_ready = 1'b0;
    rsp_item_t       rsp_item;

    table_scoreboard sb = new();
    bit              no_idle  = 1'b0;
    bit              hold_arm = 1'b0;

    keyed_table_with_compacting_delete_top #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        do
            k = $urandom;
        while (sb.locate(k) >= 0);
        return k;
    endfunction

    // usually a live key, sometimes an arbitrary one
    function automatic logic [KEY_W-1:0] some_key();
        if (sb.used > 0 && $urandom_range(0, 3) != 0)
            return sb.keys[$urandom_range(0, sb.used - 1)];
        return $urandom;
    endfunction

    // offer one request and hold it until transfer
    task automatic send(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k, logic [KEY_W-1:0] q);
        req_item_t   it;
        int unsigned gap;
        it.action        = act;
        it.item_key      = k;
        it.item_quantity = q;
        req_valid <= 1'b1;
        req_item  <= it;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(it);
        gap = idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_request();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 34)
        begin
            if (sb.used > 0 && $urandom_range(0, 4) == 0)
                send(ACT_ADD, sb.keys[$urandom_range(0, sb.used - 1)], $urandom);
            else
                send(ACT_ADD, fresh_key(), $urandom);
        end
        else if (sel < 50)
            send(ACT_DELETE, some_key(), $urandom);
        else if (sel < 64)
            send(ACT_SEARCH, some_key(), $urandom);
        else if (sel < 78)
            send(ACT_UPDATE, some_key(), $urandom);
        else if (sel < 86)
            send(ACT_LIST, $urandom, $urandom);
        else
            send(ACT_CLEAR, $urandom, $urandom);
    endtask

    // response side: check every transfer, then pick the next ready level
    initial
    begin
        int unsigned stall;
        int unsigned hold;
        bit          hold_used;
        stall     = 0;
        hold      = 0;
        hold_used = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp_item);
            if (hold_arm && !hold_used)
            begin
                hold_used = 1'b1;
                hold      = HOLD_LEN;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                stall = idle_len();
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_MAX)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("keyed_table_with_compacting_delete_top verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        int unsigned mixed;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table cases
        send(ACT_LIST, 32'd0, 32'd0);
        send(ACT_DELETE, 32'd5, 32'd0);
        send(ACT_SEARCH, 32'd5, 32'd0);
        send(ACT_UPDATE, 32'd5, 32'd9);
        // key and quantity extremes
        send(ACT_ADD, 32'h8000_0000, 32'h7fff_ffff);
        send(ACT_ADD, 32'h7fff_ffff, 32'h8000_0000);
        send(ACT_ADD, 32'h0000_0000, 32'h0000_0000);
        send(ACT_ADD, 32'hffff_ffff, 32'hffff_ffff);
        // duplicate key, lookups, update
        send(ACT_ADD, 32'h0000_0000, 32'd55);
        send(ACT_SEARCH, 32'h7fff_ffff, 32'd0);
        send(ACT_UPDATE, 32'h0000_0000, 32'd12345);
        send(ACT_SEARCH, 32'hffff_ffff, 32'd0);
        // reserved codes, no response
        send(ACT_RSVD_A, 32'h0000_0000, 32'd1);
        send(ACT_RSVD_B, $urandom, $urandom);
        send(ACT_LIST, 32'd0, 32'd0);
        // compaction from middle, last and first place
        send(ACT_DELETE, 32'h7fff_ffff, 32'd0);
        send(ACT_DELETE, 32'd42, 32'd0);
        send(ACT_LIST, 32'd0, 32'd0);
        send(ACT_DELETE, 32'hffff_ffff, 32'd0);
        send(ACT_DELETE, 32'h8000_0000, 32'd0);
        send(ACT_DELETE, 32'h0000_0000, 32'd0);
        // clear on a non-empty table
        send(ACT_ADD, 32'd9, 32'd3);
        send(ACT_CLEAR, 32'd0, 32'd0);
        send(ACT_LIST, 32'd0, 32'd0);
        send(ACT_SEARCH, 32'd9, 32'd0);

        // mixed random requests, with a stretch of no idling
        mixed = 0;
        while (mixed < MIXED_OPS)
        begin
            no_idle = (mixed >= 4 && mixed < 9);
            if ($urandom_range(0, 99) < 4)
                send($urandom_range(0, 1) ? ACT_RSVD_A : ACT_RSVD_B, $urandom, $urandom);
            else
            begin
                random_request();
                mixed++;
            end
        end
        no_idle = 1'b0;

        // fill to capacity while the response side holds off
        hold_arm = 1'b1;
        while (sb.used < DEPTH)
            send(ACT_ADD, fresh_key(), $urandom);
        send(ACT_ADD, fresh_key(), $urandom);
        send(ACT_ADD, sb.keys[$urandom_range(0, DEPTH - 1)], $urandom);
        send(ACT_LIST, $urandom, $urandom);
        repeat (12)
        begin
            case ($urandom_range(0, 2))
                0:       send(ACT_DELETE, some_key(), $urandom);
                1:       send(ACT_SEARCH, some_key(), $urandom);
                default: send(ACT_UPDATE, some_key(), $urandom);
            endcase
        end
        send(ACT_ADD, fresh_key(), $urandom);
        send(ACT_DELETE, sb.keys[sb.used - 1], $urandom);
        send(ACT_DELETE, sb.keys[0], $urandom);
        send(ACT_LIST, $urandom, $urandom);
        send(ACT_CLEAR, $urandom, $urandom);
        send(ACT_LIST, $urandom, $urandom);
        req_valid <= 1'b0;

        // drain, then allow for any stray response
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_LEN) @(posedge clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("keyed_table_with_compacting_delete_top verification clean");
        else
            $display("keyed_table_with_compacting_delete_top verification failed");
        $finish;
    end

endmodule

### keyed_table_with_compacting_delete_top.f
sv/ktcd_pkg.sv
sv/ktcd_datapath.sv
sv/ktcd_controller.sv
sv/keyed_table_with_compacting_delete_top.sv
tb/sv/testbench.sv
